// File: rtl/core/cdscan_pkg.sv
// ----------------------------------------------------------------------------
// cdscan_pkg - shared types, tables and helpers for the digit scan core
// glyph and bar tables, slot codes and the small digit split helpers
// ----------------------------------------------------------------------------
package cdscan_pkg;

	typedef logic [3:0] slot_t;
	typedef logic [8:0] lines_t;

	localparam slot_t SLOT_SPO2_TENS = 4'd0;
	localparam slot_t SLOT_SPO2_ONES = 4'd1;
	localparam slot_t SLOT_PULSE_HUND = 4'd2;
	localparam slot_t SLOT_PULSE_TENS = 4'd3;
	localparam slot_t SLOT_PULSE_ONES = 4'd4;
	localparam slot_t SLOT_PERF_HUND = 4'd5;
	localparam slot_t SLOT_PERF_TENS = 4'd6;
	localparam slot_t SLOT_PERF_ONES = 4'd7;
	localparam slot_t SLOT_STATUS = 4'd8;

	localparam logic [7:0] DOT_CLEAR = 8'h7f;
	localparam lines_t HEART_LINE = 9'h020;

	// common-anode hex glyphs, bit 7 is the dot, 0 lights a segment
	localparam logic [7:0] GLYPH [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	// per status level: lines touched, lines driven, lines driven high
	localparam lines_t BAR_NAMED [8] = '{
		9'h1ff, 9'h1bf, 9'h1bf, 9'h1bf, 9'h1bf, 9'h1bf, 9'h1bf, 9'h000
	};
	localparam lines_t BAR_ENABLE [8] = '{
		9'h000, 9'h180, 9'h101, 9'h103, 9'h107, 9'h10f, 9'h11f, 9'h000
	};
	localparam lines_t BAR_LEVEL [8] = '{
		9'h000, 9'h080, 9'h100, 9'h100, 9'h100, 9'h100, 9'h100, 9'h000
	};

	// tens of a value below 128 (up to 12)
	function automatic logic [3:0] tens_of(logic [6:0] x);
		logic [3:0] t;
		t = 4'd0;
		for (int i = 1; i <= 12; i++) begin
			if (x >= 7'(i * 10))
				t = 4'(i);
		end
		return t;
	endfunction

	function automatic logic [3:0] ones_of(logic [6:0] x);
		logic [6:0] r;
		r = x - ({3'b000, tens_of(x)} * 7'd10);
		return r[3:0];
	endfunction

	// hundreds of a 9-bit value (up to 5)
	function automatic logic [2:0] hund_of(logic [8:0] v);
		logic [2:0] h;
		h = 3'd0;
		for (int i = 1; i <= 5; i++) begin
			if (v >= 9'(i * 100))
				h = 3'(i);
		end
		return h;
	endfunction

	function automatic logic [6:0] rem100(logic [8:0] v);
		logic [8:0] r;
		r = v - ({6'b000000, hund_of(v)} * 9'd100);
		return r[6:0];
	endfunction

	// common line k, pattern spread over the other eight lines in order
	function automatic lines_t digit_enables(logic [2:0] k, logic [7:0] pat);
		lines_t kbit;
		lines_t low;
		kbit = 9'd1 << k;
		low = kbit - 9'd1;
		return ({1'b0, ~pat} & low) | ({~pat, 1'b0} & ~low & ~kbit) | kbit;
	endfunction

endpackage

// File: rtl/core/charlieplexed_digit_scan_core.sv
// ----------------------------------------------------------------------------
// charlieplexed_digit_scan_core - charlieplexed seven-segment scan core
// one scan tick in, one nine-line drive pattern out
// ----------------------------------------------------------------------------
// usage
//   each request on the slave stream is one scan tick carrying the current
//   spo2, pulse and perfusion values plus the status bar level and heart sign
//   each tick yields exactly one request on the master stream with the line
//   enables, line levels and the slot that was shown
//   slots run spo2 tens/ones, pulse hundreds/tens/ones, perfusion
//   hundreds/tens/ones, then the status bar; a zero perfusion hundreds digit
//   is skipped, the tick shows the perfusion tens instead
//   values are sampled on the first tick of their group
// timing
//   an accepted tick passes through the input register, then the slot decode
//   and digit split into the result register
//   one tick per cycle while m_tready stays high; with both registers full,
//   s_tready follows m_tready combinationally
// reset and stall
//   arst_n clears the scan position, held values and the drive state (all
//   lines floating); a stalled master holds its result and fills the input
//   register, after which s_tready drops
// ----------------------------------------------------------------------------
module charlieplexed_digit_scan_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] spo2_value, [15:7] pulse_value, [24:16] perfusion_value,
	// [27:25] status_level, [28] heart_sign, [31:29] zero
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] line_enable, [17:9] line_level, [21:18] slot_shown, [23:22] zero
	output logic [23:0] m_tdata
);

	// input register
	logic       in_valid_s1;
	logic [6:0] spo2_s1;
	logic [8:0] pulse_s1;
	logic [8:0] perf_s1;
	logic [2:0] level_s1;
	logic       heart_s1;

	// scan state, doubles as the result register
	cdscan_pkg::slot_t  scan_slot_q;
	logic [6:0]         spo2_held_q;
	logic [8:0]         pulse_held_q;
	logic [8:0]         perf_held_q;
	cdscan_pkg::lines_t drive_enables_q;
	cdscan_pkg::lines_t drive_levels_q;
	cdscan_pkg::slot_t  shown_q;
	logic               out_valid_q;

	logic advance;

	// slot decode
	logic [2:0]         digit_k;
	logic [7:0]         digit_pat;
	logic               is_status;
	cdscan_pkg::slot_t  shown_d;
	cdscan_pkg::slot_t  next_slot;
	logic [2:0]         hund_d;
	cdscan_pkg::lines_t bar_en;
	cdscan_pkg::lines_t bar_lv;
	cdscan_pkg::lines_t next_en;
	cdscan_pkg::lines_t next_lv;

	// a tick moves on whenever the result register is free or being emptied
	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			spo2_s1  <= s_tdata[6:0];
			pulse_s1 <= s_tdata[15:7];
			perf_s1  <= s_tdata[24:16];
			level_s1 <= s_tdata[27:25];
			heart_s1 <= s_tdata[28];
		end
	end

	// per slot: which common line, which glyph, where the scan goes next
	always_comb begin
		digit_k   = scan_slot_q[2:0];
		digit_pat = 8'hff;
		is_status = 1'b0;
		shown_d   = scan_slot_q;
		next_slot = scan_slot_q + 4'd1;
		hund_d    = 3'd0;
		case (scan_slot_q)
			cdscan_pkg::SLOT_SPO2_TENS: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::tens_of(spo2_s1)];
			end
			cdscan_pkg::SLOT_SPO2_ONES: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::ones_of(spo2_held_q)];
			end
			cdscan_pkg::SLOT_PULSE_HUND: begin
				// zero hundreds shows a blank digit with only the dot lit
				hund_d = cdscan_pkg::hund_of(pulse_s1);
				if (hund_d != 3'd0)
					digit_pat = cdscan_pkg::GLYPH[{1'b0, hund_d}] & cdscan_pkg::DOT_CLEAR;
				else
					digit_pat = cdscan_pkg::DOT_CLEAR;
			end
			cdscan_pkg::SLOT_PULSE_TENS: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::tens_of(
					cdscan_pkg::rem100(pulse_held_q))] & cdscan_pkg::DOT_CLEAR;
			end
			cdscan_pkg::SLOT_PULSE_ONES: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::ones_of(
					cdscan_pkg::rem100(pulse_held_q))] & cdscan_pkg::DOT_CLEAR;
			end
			cdscan_pkg::SLOT_PERF_HUND: begin
				// zero hundreds: skip straight to the tens digit
				hund_d = cdscan_pkg::hund_of(perf_s1);
				if (hund_d != 3'd0) begin
					digit_pat = cdscan_pkg::GLYPH[{1'b0, hund_d}];
				end else begin
					digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::tens_of(
						cdscan_pkg::rem100(perf_s1))];
					digit_k   = cdscan_pkg::SLOT_PERF_TENS[2:0];
					shown_d   = cdscan_pkg::SLOT_PERF_TENS;
					next_slot = cdscan_pkg::SLOT_PERF_ONES;
				end
			end
			cdscan_pkg::SLOT_PERF_TENS: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::tens_of(
					cdscan_pkg::rem100(perf_held_q))];
			end
			cdscan_pkg::SLOT_PERF_ONES: begin
				digit_pat = cdscan_pkg::GLYPH[cdscan_pkg::ones_of(
					cdscan_pkg::rem100(perf_held_q))] & cdscan_pkg::DOT_CLEAR;
			end
			default: begin
				// status bar, also covers the unused slot codes
				is_status = 1'b1;
				shown_d   = cdscan_pkg::SLOT_STATUS;
				next_slot = cdscan_pkg::SLOT_SPO2_TENS;
			end
		endcase
	end

	// status bar only touches the lines its level names, plus the heart line when the heart sign is set
	always_comb begin
		bar_en = (drive_enables_q & ~cdscan_pkg::BAR_NAMED[level_s1])
			| cdscan_pkg::BAR_ENABLE[level_s1];
		bar_lv = (drive_levels_q & ~cdscan_pkg::BAR_NAMED[level_s1])
			| cdscan_pkg::BAR_LEVEL[level_s1];
		if (heart_s1) begin
			bar_en = bar_en | cdscan_pkg::HEART_LINE;
			bar_lv = bar_lv & ~cdscan_pkg::HEART_LINE;
		end
		bar_lv = bar_lv & bar_en;
	end

	always_comb begin
		if (is_status) begin
			next_en = bar_en;
			next_lv = bar_lv;
		end else begin
			next_en = cdscan_pkg::digit_enables(digit_k, digit_pat);
			next_lv = 9'd1 << digit_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_slot_q     <= cdscan_pkg::SLOT_SPO2_TENS;
			spo2_held_q     <= 7'd0;
			pulse_held_q    <= 9'd0;
			perf_held_q     <= 9'd0;
			drive_enables_q <= '0;
			drive_levels_q  <= '0;
			shown_q         <= cdscan_pkg::SLOT_SPO2_TENS;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				scan_slot_q     <= next_slot;
				drive_enables_q <= next_en;
				drive_levels_q  <= next_lv;
				shown_q         <= shown_d;
				if (scan_slot_q == cdscan_pkg::SLOT_SPO2_TENS)
					spo2_held_q <= spo2_s1;
				if (scan_slot_q == cdscan_pkg::SLOT_PULSE_HUND)
					pulse_held_q <= pulse_s1;
				if (scan_slot_q == cdscan_pkg::SLOT_PERF_HUND)
					perf_held_q <= perf_s1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, shown_q, drive_levels_q, drive_enables_q};

`ifndef ASSERT_OFF
	// a floating line never carries a level
	a_level_within_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_levels_q & ~drive_enables_q) == 9'd0)
		else $error("line level set on a floating line");

	// the scan never leaves the nine slots
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_slot_q <= cdscan_pkg::SLOT_STATUS)
		else $error("scan slot out of range");

	// after the status bar the scan wraps to the first digit
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_status |=> scan_slot_q == cdscan_pkg::SLOT_SPO2_TENS)
		else $error("scan did not wrap after status slot");

	// a digit tick drives exactly its common line high
	a_digit_common: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_status |=> $onehot(drive_levels_q))
		else $error("digit tick without a single common line");
`endif

endmodule
